FILE: hdl/clfr_pkg.sv
// Shared types, request codes and panel command constants for the character LCD refresh engine.
package clfr_pkg;

  localparam logic [2:0] REQ_WRITE = 3'd0;
  localparam logic [2:0] REQ_CLEAR = 3'd1;
  localparam logic [2:0] REQ_FLUSH = 3'd2;
  localparam logic [2:0] REQ_GLYPH = 3'd3;
  localparam logic [2:0] REQ_INIT  = 3'd4;

  localparam logic [7:0] SPACE_CHAR  = 8'h20;
  localparam logic [7:0] CGRAM_BASE  = 8'h40;
  localparam logic [7:0] RESET_ADDR  = 8'h80;
  localparam int         INIT_LEN    = 9;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  column;
    logic [1:0]  row;
    logic [7:0]  char_code;
    logic [2:0]  glyph_slot;
    logic [55:0] glyph_rows;
  } req_item_t;

  typedef struct packed {
    logic       send_command;
    logic [7:0] command_byte;
    logic       send_data;
    logic [7:0] data_byte;
    logic       last;
  } res_item_t;

  function automatic logic [7:0] init_cmd(input logic [3:0] idx);
    logic [7:0] cmd;
    unique case (idx)
      4'd0, 4'd1, 4'd2: cmd = 8'h30;
      4'd3: cmd = 8'h38;
      4'd4: cmd = 8'h08;
      4'd5: cmd = 8'h01;
      4'd6: cmd = 8'h06;
      4'd7: cmd = 8'h0c;
      4'd8: cmd = 8'h14;
      default: cmd = 8'h00;
    endcase
    return cmd;
  endfunction

endpackage

FILE: hdl/clfr_if.sv
// Request and result channel interfaces for the character LCD refresh engine.
interface clfr_req_if;
  logic                 valid;
  logic                 ready;
  clfr_pkg::req_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface clfr_res_if;
  logic                 valid;
  logic                 ready;
  clfr_pkg::res_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/clfr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module clfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/char_lcd_frame_refresh.sv
// Character LCD refresh engine: pending and shadow frame memories, glyph cache and command sequencer.
//
// A write or a clear request gives no result. A flush scans the frame one cell per cycle
// through the read port of the pending and shadow memories, and pauses while a changed cell
// waits on a result register held by the sink. A changed glyph gives CELL_HEIGHT results and
// an init gives nine, one per cycle while the sink keeps up. The frames reset to spaces
// through per-cell valid bits, so there is no clearing pass after reset. Requests are taken
// one at a time; the next request is accepted as soon as the last result of the previous one
// sits in the output register.
module char_lcd_frame_refresh #(
  parameter int COLUMNS     = 20,
  parameter int ROWS        = 2,
  parameter int CELL_WIDTH  = 5,
  parameter int CELL_HEIGHT = 7,
  parameter int GLYPH_SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst,
  clfr_req_if.sink   req,
  clfr_res_if.source res
);

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CELL_CW = $clog2(CELLS + 1);
  localparam int SLOT_AW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam int GW      = CELL_WIDTH * CELL_HEIGHT;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FLUSH = 4'b0010,
    ST_GLYPH = 4'b0100,
    ST_INIT  = 4'b1000
  } state_t;

  state_t state;

  logic [CELLS-1:0]   pvalid;
  logic [CELLS-1:0]   svalid;
  logic [GW-1:0]      gcache [GLYPH_SLOTS];
  logic [GLYPH_SLOTS-1:0] gvalid;
  logic [7:0]         last_addr;
  logic               la_valid;

  logic [CELL_CW-1:0] scan_addr;
  logic [5:0]         scan_col;
  logic               scan_row;
  logic               cmp_valid;
  logic [CELL_AW-1:0] cmp_addr;
  logic [5:0]         cmp_col;
  logic               cmp_row;
  logic               held_valid;
  clfr_pkg::res_item_t held_item;

  logic [GW-1:0]      gbuf;
  logic [2:0]         gslot;
  logic [2:0]         gidx;
  logic [3:0]         iidx;

  logic               out_valid;
  clfr_pkg::res_item_t out_item;

  logic               accept;
  logic               out_free;
  logic [7:0]         pend_rd;
  logic [7:0]         shad_rd;
  logic [7:0]         pend_c;
  logic [7:0]         shad_c;
  logic [7:0]         cell_addr;
  logic               follows;
  logic               diff;
  logic               stall;
  logic               scan_done;
  logic               rd_en;
  logic               sh_we;
  logic               pd_we;
  logic               wr_in_range;
  logic [6:0]         wr_cell_full;
  logic [CELL_AW-1:0] wr_cell;
  logic               slot_ok;
  logic [SLOT_AW-1:0] slot_idx;
  logic [63:0]        rows_ext;
  logic [GW-1:0]      packed_glyph;
  logic               glyph_hit;
  logic [CELL_WIDTH-1:0] gline;
  logic               out_load;
  clfr_pkg::res_item_t out_load_item;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign res.valid = out_valid;
  assign res.payload = out_item;
  assign out_free  = !out_valid || res.ready;

  assign wr_in_range  = (req.payload.column < 6'(COLUMNS)) && (req.payload.row < 2'(ROWS));
  assign wr_cell_full = {1'b0, req.payload.column} + (req.payload.row[0] ? 7'(COLUMNS) : 7'd0);
  assign wr_cell      = wr_cell_full[CELL_AW-1:0];
  assign pd_we        = accept && (req.payload.req_type == clfr_pkg::REQ_WRITE) && wr_in_range;

  assign pend_c    = pvalid[cmp_addr] ? pend_rd : clfr_pkg::SPACE_CHAR;
  assign shad_c    = svalid[cmp_addr] ? shad_rd : clfr_pkg::SPACE_CHAR;
  assign cell_addr = {1'b1, cmp_row, cmp_col};
  assign follows   = la_valid && (({1'b0, last_addr} + 9'd1) == {1'b0, cell_addr});
  assign diff      = (state == ST_FLUSH) && cmp_valid && (pend_c != shad_c);
  assign stall     = diff && held_valid && !out_free;
  assign scan_done = (scan_addr == CELL_CW'(CELLS));
  assign rd_en     = (state == ST_FLUSH) && !stall && !scan_done;
  assign sh_we     = diff && !stall;

  assign slot_ok   = {1'b0, req.payload.glyph_slot} < 4'(GLYPH_SLOTS);
  assign slot_idx  = req.payload.glyph_slot[SLOT_AW-1:0];
  assign rows_ext  = {8'h00, req.payload.glyph_rows};
  assign glyph_hit = gvalid[slot_idx] && (gcache[slot_idx] == packed_glyph);
  assign gline     = gbuf[gidx*CELL_WIDTH +: CELL_WIDTH];

  always_comb begin
    for (int i = 0; i < CELL_HEIGHT; i++) begin
      packed_glyph[i*CELL_WIDTH +: CELL_WIDTH] = rows_ext[8*i +: CELL_WIDTH];
    end
  end

  always_comb begin
    out_load      = 1'b0;
    out_load_item = held_item;
    unique case (state)
      ST_FLUSH: begin
        if (diff && held_valid && out_free) begin
          out_load           = 1'b1;
          out_load_item.last = 1'b0;
        end else if (scan_done && !cmp_valid && held_valid && out_free) begin
          out_load           = 1'b1;
          out_load_item.last = 1'b1;
        end
      end
      ST_GLYPH: begin
        out_load      = out_free;
        out_load_item = '{send_command: 1'b1,
                          command_byte: clfr_pkg::CGRAM_BASE | {2'b00, gslot, gidx},
                          send_data: 1'b1,
                          data_byte: 8'(gline),
                          last: (gidx == 3'(CELL_HEIGHT - 1))};
      end
      ST_INIT: begin
        out_load      = out_free;
        out_load_item = '{send_command: 1'b1,
                          command_byte: clfr_pkg::init_cmd(iidx),
                          send_data: 1'b0,
                          data_byte: 8'h00,
                          last: (iidx == 4'(clfr_pkg::INIT_LEN - 1))};
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  clfr_ram #(.WIDTH(8), .DEPTH(CELLS)) u_pending (
    .clk     (clk),
    .wr_en   (pd_we),
    .wr_addr (wr_cell),
    .wr_data (req.payload.char_code),
    .rd_en   (rd_en),
    .rd_addr (scan_addr[CELL_AW-1:0]),
    .rd_data (pend_rd)
  );

  clfr_ram #(.WIDTH(8), .DEPTH(CELLS)) u_shadow (
    .clk     (clk),
    .wr_en   (sh_we),
    .wr_addr (cmp_addr),
    .wr_data (pend_c),
    .rd_en   (rd_en),
    .rd_addr (scan_addr[CELL_AW-1:0]),
    .rd_data (shad_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pvalid     <= '0;
      svalid     <= '0;
      gvalid     <= '0;
      last_addr  <= clfr_pkg::RESET_ADDR;
      la_valid   <= 1'b1;
      cmp_valid  <= 1'b0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_item  <= out_load_item;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.payload.req_type)
              clfr_pkg::REQ_WRITE: begin
                if (wr_in_range) begin
                  pvalid[wr_cell] <= 1'b1;
                end
              end
              clfr_pkg::REQ_CLEAR: begin
                pvalid <= '0;
              end
              clfr_pkg::REQ_FLUSH: begin
                scan_addr  <= '0;
                scan_col   <= '0;
                scan_row   <= 1'b0;
                cmp_valid  <= 1'b0;
                held_valid <= 1'b0;
                state      <= ST_FLUSH;
              end
              clfr_pkg::REQ_GLYPH: begin
                if (slot_ok && !glyph_hit) begin
                  gcache[slot_idx] <= packed_glyph;
                  gvalid[slot_idx] <= 1'b1;
                  la_valid         <= 1'b0;
                  gbuf             <= packed_glyph;
                  gslot            <= req.payload.glyph_slot;
                  gidx             <= '0;
                  state            <= ST_GLYPH;
                end
              end
              clfr_pkg::REQ_INIT: begin
                svalid   <= '0;
                la_valid <= 1'b0;
                iidx     <= '0;
                state    <= ST_INIT;
              end
              default: begin
              end
            endcase
          end
        end
        ST_FLUSH: begin
          if (!stall) begin
            if (!scan_done) begin
              cmp_valid <= 1'b1;
              cmp_addr  <= scan_addr[CELL_AW-1:0];
              cmp_col   <= scan_col;
              cmp_row   <= scan_row;
              scan_addr <= scan_addr + CELL_CW'(1);
              if (scan_col == 6'(COLUMNS - 1)) begin
                scan_col <= '0;
                scan_row <= 1'b1;
              end else begin
                scan_col <= scan_col + 6'd1;
              end
            end else begin
              cmp_valid <= 1'b0;
            end
            if (diff) begin
              svalid[cmp_addr] <= 1'b1;
              last_addr        <= cell_addr;
              la_valid         <= 1'b1;
              held_valid       <= 1'b1;
              held_item        <= '{send_command: !follows,
                                    command_byte: follows ? 8'h00 : cell_addr,
                                    send_data: 1'b1,
                                    data_byte: pend_c,
                                    last: 1'b0};
            end
          end
          if (scan_done && !cmp_valid && (!held_valid || out_free)) begin
            held_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        ST_GLYPH: begin
          if (out_free) begin
            gidx <= gidx + 3'd1;
            if (gidx == 3'(CELL_HEIGHT - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_INIT: begin
          if (out_free) begin
            iidx <= iidx + 4'd1;
            if (iidx == 4'(clfr_pkg::INIT_LEN - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/clfr_checker.sv
// Port-level checker for the character LCD refresh engine and its bind to the top level.
module clfr_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic [2:0]          req_type,
  input logic                res_valid,
  input logic                res_ready,
  input clfr_pkg::res_item_t res_payload
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_payload))
    else $error("Stalled result changed or was dropped.");

  a_res_nonempty: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_payload.send_command || res_payload.send_data)
    else $error("Result carries neither a command nor data.");

  a_res_zero_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_payload.send_command || res_payload.command_byte == 8'h00) &&
                  (res_payload.send_data || res_payload.data_byte == 8'h00))
    else $error("Unused result byte is not zero.");

  a_init_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_type == clfr_pkg::REQ_INIT |=> !req_ready)
    else $error("Init request did not hold off the next request.");

endmodule

bind char_lcd_frame_refresh clfr_checker u_clfr_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_type    (req.payload.req_type),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_payload (res.payload)
);
